// ===== sv/cms_pkg.sv =====
// completion match store package: sizes, slot entry layout and the
// command and status bundles between the controller and the datapath
// no dependencies
package cms_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LINK_W  = $clog2(ENTRIES + 1);
  localparam int OCC_W   = LINK_W;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // first member sits in the highest bits, so request_id lands lowest
  typedef struct packed {
    logic [31:0] byte_length;
    logic [7:0]  opcode;
    logic [4:0]  status;
    logic [23:0] queue_number;
    logic [63:0] request_id;
  } entry_t;

  localparam int ENTRY_W  = $bits(entry_t);
  localparam int IN_TD_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_TD_W = ((ENTRY_W + OCC_W + 7) / 8) * 8;

  typedef struct packed {
    logic load_item;
    logic set_cur_free;
    logic set_cur_head;
    logic data_wr;
    logic add_link;
    logic add_tail;
    logic step;
    logic unlink;
    logic release_slot;
    logic set_ok;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic free_empty;
    logic head_null;
    logic match;
    logic nxt_null;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/cms_ctrl.sv =====
// completion match store controller: sequences add and find beats
// depends on cms_pkg
module cms_ctrl
  import cms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_command,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ADD      = 4'd1;
  localparam logic [3:0] ST_ADD_RD   = 4'd2;
  localparam logic [3:0] ST_ADD_LNK  = 4'd3;
  localparam logic [3:0] ST_ADD_TAIL = 4'd4;
  localparam logic [3:0] ST_FIND     = 4'd5;
  localparam logic [3:0] ST_F_RD     = 4'd6;
  localparam logic [3:0] ST_F_CHK    = 4'd7;
  localparam logic [3:0] ST_F_REL    = 4'd8;
  localparam logic [3:0] ST_RESULT   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = (in_command == CMD_FIND) ? ST_FIND : ST_ADD;
        end
      end
      ST_ADD: begin
        if (sts.free_empty) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.set_cur_free = 1'b1;
          state_nxt        = ST_ADD_RD;
        end
      end
      ST_ADD_RD: begin
        state_nxt = ST_ADD_LNK;
      end
      ST_ADD_LNK: begin
        cmd.data_wr  = 1'b1;
        cmd.add_link = 1'b1;
        state_nxt    = ST_ADD_TAIL;
      end
      ST_ADD_TAIL: begin
        cmd.add_tail = 1'b1;
        cmd.set_ok   = 1'b1;
        state_nxt    = ST_RESULT;
      end
      ST_FIND: begin
        if (sts.head_null) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.set_cur_head = 1'b1;
          state_nxt        = ST_F_RD;
        end
      end
      ST_F_RD: begin
        state_nxt = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (sts.match) begin
          cmd.unlink = 1'b1;
          cmd.set_ok = 1'b1;
          state_nxt  = ST_F_REL;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = sts.nxt_null ? ST_RESULT : ST_F_RD;
        end
      end
      ST_F_REL: begin
        cmd.release_slot = 1'b1;
        state_nxt        = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/cms_dp.sv =====
// completion match store datapath: slot and link memories, list pointers,
// walk registers and the output register
// depends on cms_pkg
module cms_dp
  import cms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  entry_t            in_entry,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_ok,
  output entry_t            out_entry,
  output logic [OCC_W-1:0]  out_occupancy
);

  entry_t             data_mem [ENTRIES];
  logic [LINK_W-1:0]  link_mem [ENTRIES];
  logic [ENTRIES-1:0] link_vld_r;

  entry_t             item_r;
  entry_t             data_q_r;
  logic [LINK_W-1:0]  link_q_r;
  logic               link_hit_r;
  logic [IDX_W-1:0]   link_addr_r;
  logic [LINK_W-1:0]  link_rd;

  logic [LINK_W-1:0]  cur_r;
  logic [LINK_W-1:0]  prev_r;
  logic [LINK_W-1:0]  head_r;
  logic [LINK_W-1:0]  tail_r;
  logic [LINK_W-1:0]  free_r;
  logic [OCC_W-1:0]   count_r;
  entry_t             found_r;
  logic               ok_r;

  logic               out_valid_r;
  logic               out_ok_r;
  entry_t             out_entry_r;
  logic [OCC_W-1:0]   out_occ_r;

  logic               lk_we;
  logic [LINK_W-1:0]  lk_waddr;
  logic [LINK_W-1:0]  lk_wdata;
  logic [IDX_W-1:0]   rd_addr;

  assign rd_addr = cur_r[IDX_W-1:0];

  // an unwritten link still holds its reset chain value
  assign link_rd = link_hit_r ? link_q_r : (LINK_W'(link_addr_r) + LINK_W'(1));

  assign sts.free_empty = (free_r == NIL_LINK);
  assign sts.head_null  = (head_r == NIL_LINK);
  assign sts.match      = (data_q_r.request_id == item_r.request_id) &&
                          (data_q_r.queue_number == item_r.queue_number);
  assign sts.nxt_null   = (link_rd == NIL_LINK);
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = cur_r;
    lk_wdata = NIL_LINK;
    if (cmd.add_link) begin
      lk_we = 1'b1;
    end else if (cmd.add_tail && (head_r != NIL_LINK)) begin
      lk_we    = 1'b1;
      lk_waddr = tail_r;
      lk_wdata = cur_r;
    end else if (cmd.unlink && (prev_r != NIL_LINK)) begin
      lk_we    = 1'b1;
      lk_waddr = prev_r;
      lk_wdata = link_rd;
    end else if (cmd.release_slot) begin
      lk_we    = 1'b1;
      lk_wdata = free_r;
    end
  end

  // slot and link memories
  always_ff @(posedge clk) begin
    if (cmd.data_wr) begin
      data_mem[rd_addr] <= item_r;
    end
    data_q_r <= data_mem[rd_addr];
    if (lk_we) begin
      link_mem[lk_waddr[IDX_W-1:0]] <= lk_wdata;
    end
    link_q_r    <= link_mem[rd_addr];
    link_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
      link_hit_r <= 1'b0;
    end else begin
      link_hit_r <= link_vld_r[rd_addr];
      if (lk_we) begin
        link_vld_r[lk_waddr[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  // list pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NIL_LINK;
      tail_r  <= NIL_LINK;
      free_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.add_link) begin
        free_r <= link_rd;
      end
      if (cmd.add_tail) begin
        if (head_r == NIL_LINK) begin
          head_r <= cur_r;
        end
        tail_r  <= cur_r;
        count_r <= count_r + OCC_W'(1);
      end
      if (cmd.unlink) begin
        if (prev_r == NIL_LINK) begin
          head_r <= link_rd;
          if (link_rd == NIL_LINK) begin
            tail_r <= NIL_LINK;
          end
        end else if (link_rd == NIL_LINK) begin
          tail_r <= prev_r;
        end
      end
      if (cmd.release_slot) begin
        free_r  <= cur_r;
        count_r <= count_r - OCC_W'(1);
      end
    end
  end

  // walk and item registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r  <= in_entry;
      found_r <= '0;
      ok_r    <= 1'b0;
    end
    if (cmd.set_ok) begin
      ok_r <= 1'b1;
    end
    if (cmd.unlink) begin
      found_r <= data_q_r;
    end
    if (cmd.set_cur_free) begin
      cur_r <= free_r;
    end
    if (cmd.set_cur_head) begin
      cur_r  <= head_r;
      prev_r <= NIL_LINK;
    end
    if (cmd.step) begin
      prev_r <= cur_r;
      cur_r  <= link_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_ok_r    <= ok_r;
      out_entry_r <= found_r;
      out_occ_r   <= count_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_entry     = out_entry_r;
  assign out_occupancy = out_occ_r;

endmodule

// ===== sv/completion_match_store.sv =====
// completion match store top level: stream ports around controller and datapath
// depends on cms_pkg, cms_ctrl, cms_dp
//
// in_ beats carry one command: in_tuser 0 adds a completion, 1 finds and
// removes the oldest entry with the same request id and queue number.
// every command answers with exactly one out_ beat: out_tuser is ok, tdata
// holds the removed entry (zero otherwise) and the occupancy after the command.
// an add on a full store answers with ok low and stores nothing; a find walks
// the list from the oldest entry and visits up to 64 entries, each visit
// waiting on the registered read of the slot and link memories.
// one command is worked on at a time; in_tready is high only while idle.
// a finished result waits in the output register while the next command is
// taken in; a stalled receiver holds the store only at its result step.
// reset empties the store at once: head, tail, count and link valid bits
// clear together under reset, so no clearing pass is needed and in_tready is high
// straight after reset.
module completion_match_store
  import cms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // request_id, queue_number, completion_status, completion_opcode, byte_length
  input  logic [IN_TD_W-1:0]  in_tdata,
  // command
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // found_request_id, found_queue_number, found_status, found_opcode,
  // found_byte_length, occupancy
  output logic [OUT_TD_W-1:0] out_tdata,
  // ok
  output logic                out_tuser
);

  cmd_t             cmd;
  sts_t             sts;
  entry_t           in_entry;
  entry_t           out_entry;
  logic [OCC_W-1:0] out_occ;

  assign in_entry = entry_t'(in_tdata[ENTRY_W-1:0]);

  cms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_command (in_tuser),
    .in_ready   (in_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cms_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_entry      (in_entry),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_ok        (out_tuser),
    .out_entry     (out_entry),
    .out_occupancy (out_occ)
  );

  assign out_tdata = OUT_TD_W'({out_occ, out_entry});

endmodule
